// ----- hdl/disparity_to_world_point_unit_defines.svh -----
// Assertion macros shared by the disparity reprojection RTL.
// Needs a clk and an arst_n in scope at the point of use.
`ifndef DISPARITY_TO_WORLD_POINT_UNIT_DEFINES_SVH
`define DISPARITY_TO_WORLD_POINT_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// condition holds in the same cycle
`define D2WP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// condition holds in the following cycle
`define D2WP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define D2WP_ASSERT_NOW(label, ante, cons, msg)
`define D2WP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/d2wp_pkg.sv -----
// Package for the disparity reprojection unit: constants, register codes, stage types.
// No dependencies.
`timescale 1ns / 1ps
package d2wp_pkg;

	// camera constants in fixed point
	localparam logic [31:0]        FB_Q24       = 32'd2249949020;
	localparam logic [22:0]        B_Q24        = 23'd6956069;
	localparam logic signed [27:0] CX_Q16       = 28'sd20462114;
	localparam logic signed [27:0] CY_Q16       = 28'sd16518889;

	localparam int MAG_W      = 16;  // disparity magnitude
	localparam int QUO_W      = 29;  // divider dividend / quotient
	localparam int OFF_W      = 26;  // lateral offset magnitude, Q16
	localparam int ROT_W      = 18;  // one rotation coefficient
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 54;

	localparam logic [QUO_W-1:0] DEPTH_MIN_Q8 = 29'd256;
	localparam logic [QUO_W-1:0] DEPTH_MAX_Q8 = 29'd512000000;

	localparam int DEF_MAX_ROWS = 1024;
	localparam int DEF_MAX_COLS = 1024;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROT0,
		CFG_ROT1,
		CFG_ROT2,
		CFG_TX,
		CFG_TY,
		CFG_TZ,
		CFG_DIV
	} d2wp_cfg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} d2wp_color_t;

	// per-item control carried beside the divider lanes
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             z_neg;
		logic             x_neg;
		logic             y_neg;
		logic             keep;
		d2wp_color_t      color;
	} d2wp_side_t;

	// one divider lane: dividend shifting out on top, quotient in at the bottom
	typedef struct packed {
		logic [QUO_W-1:0] nq;
		logic [MAG_W-1:0] rem;
	} d2wp_lane_t;

	// one restoring division step
	function automatic d2wp_lane_t d2wp_div_step(input d2wp_lane_t l, input logic [MAG_W-1:0] d);
		logic [MAG_W:0] trial;
		logic [MAG_W:0] diff;
		logic           ge;
		d2wp_lane_t     r;
		trial = {l.rem, l.nq[QUO_W-1]};
		diff  = trial - {1'b0, d};
		ge    = (trial >= {1'b0, d});
		r.rem = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
		r.nq  = {l.nq[QUO_W-2:0], ge};
		return r;
	endfunction

endpackage

// ----- hdl/d2wp_if.sv -----
// Stream interfaces: input pixel channel and output world point channel.
// Depends on d2wp_pkg for field widths.
`timescale 1ns / 1ps
interface d2wp_pixel_if;
	import d2wp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [MAG_W-1:0] raw_disparity;
	logic [9:0]              pixel_row;
	logic [9:0]              pixel_column;
	logic [7:0]              blue;
	logic [7:0]              green;
	logic [7:0]              red;

	modport source (output valid, raw_disparity, pixel_row, pixel_column, blue, green, red,
		input ready);
	modport sink (input valid, raw_disparity, pixel_row, pixel_column, blue, green, red,
		output ready);
endinterface

interface d2wp_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] world_x;
	logic signed [31:0] world_y;
	logic signed [31:0] world_z;
	logic [7:0]         point_red;
	logic [7:0]         point_green;
	logic [7:0]         point_blue;

	modport source (output valid, world_x, world_y, world_z, point_red, point_green,
		point_blue, input ready);
	modport sink (input valid, world_x, world_y, world_z, point_red, point_green,
		point_blue, output ready);
endinterface

// ----- hdl/disparity_to_world_point_unit.sv -----
// Top level: disparity to colored world point, config registers, pre/post divide stages.
// Depends on d2wp_pkg, d2wp_if, d2wp_divider and the assertion macro header.
//
//  channel  | dir | handshake     | payload
//  pixel    | in  | valid / ready | raw_disparity, pixel_row, pixel_column, blue, green, red
//  point    | out | valid / ready | world_x, world_y, world_z, point_red/green/blue
//  cfg      | in  | cfg_wr_en     | cfg_addr, cfg_wdata (write only)
//
// One pixel per cycle unless the output stalls; 4 setup stages, 29 divider stages
// (one quotient bit each), 4 rotate/translate stages.
// Reset clears all valid bits and loads identity rotation, zero translation, divisor 64.
// A stalled output freezes the whole pipeline; rejected pixels leave as bubbles.
`timescale 1ns / 1ps
`include "disparity_to_world_point_unit_defines.svh"
module disparity_to_world_point_unit #(
	parameter int MAX_ROWS = d2wp_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = d2wp_pkg::DEF_MAX_COLS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [d2wp_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [d2wp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	d2wp_pixel_if.sink                         pixel,
	d2wp_point_if.source                       point
);
	import d2wp_pkg::*;

	// configuration registers
	logic [3*ROT_W-1:0] rot_q [3];
	logic signed [31:0] trans_q [3];
	logic [8:0]         div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0]   <= 54'd32768;
			rot_q[1]   <= 54'd32768 << ROT_W;
			rot_q[2]   <= 54'd32768 << (2*ROT_W);
			trans_q[0] <= '0;
			trans_q[1] <= '0;
			trans_q[2] <= '0;
			div_q      <= 9'd64;
		end else if (cfg_wr_en) begin
			case (d2wp_cfg_idx_t'(cfg_addr))
				CFG_ROT0: rot_q[0]   <= cfg_wdata;
				CFG_ROT1: rot_q[1]   <= cfg_wdata;
				CFG_ROT2: rot_q[2]   <= cfg_wdata;
				CFG_TX:   trans_q[0] <= cfg_wdata[31:0];
				CFG_TY:   trans_q[1] <= cfg_wdata[31:0];
				CFG_TZ:   trans_q[2] <= cfg_wdata[31:0];
				CFG_DIV:  div_q      <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// global advance: the pipeline moves unless a result waits
	logic en;
	assign en          = !point.valid || point.ready;
	assign pixel.ready = en;

	// stage 1: magnitude, offsets, divisor clamp, pixel gate
	logic               raw_neg;
	logic [MAG_W-1:0]   mag_c;
	logic signed [27:0] offx_c, offy_c;
	logic [8:0]         n_c;
	d2wp_side_t         side_c;

	always_comb begin
		raw_neg = pixel.raw_disparity[MAG_W-1];
		mag_c   = raw_neg ? (~pixel.raw_disparity + 16'd1) : pixel.raw_disparity;
		offx_c  = $signed({2'b00, pixel.pixel_column, 16'h0000}) - CX_Q16;
		offy_c  = $signed({2'b00, pixel.pixel_row, 16'h0000}) - CY_Q16;
		if (div_q == 9'd0)
			n_c = 9'd1;
		else if (div_q > 9'd256)
			n_c = 9'd256;
		else
			n_c = div_q;
		side_c.mag   = mag_c;
		side_c.z_neg = raw_neg;
		side_c.x_neg = offx_c[27] ^ raw_neg;
		side_c.y_neg = offy_c[27] ^ raw_neg;
		side_c.keep  = (pixel.raw_disparity != '0) && (int'(pixel.pixel_row) < MAX_ROWS)
			&& (int'(pixel.pixel_column) < MAX_COLS);
		side_c.color = '{red: pixel.red, green: pixel.green, blue: pixel.blue};
	end

	logic             v_s1, v_s2, v_s3, v_s4;
	d2wp_side_t       side_s1, side_s2, side_s3, side_s4;
	logic [OFF_W-1:0] omx_s1, omy_s1, omx_s2, omy_s2;
	logic [8:0]       n_s1;
	logic [40:0]      fbn_s2;
	logic [31:0]      bn_s2;
	logic [QUO_W-1:0] dz_s3, dz_s4, dx_s4, dy_s4;
	logic [57:0]      px_s3, py_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= pixel.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			side_s1 <= side_c;
			omx_s1  <= offx_c[27] ? OFF_W'(-offx_c) : offx_c[OFF_W-1:0];
			omy_s1  <= offy_c[27] ? OFF_W'(-offy_c) : offy_c[OFF_W-1:0];
			n_s1    <= n_c;
			// stage 2: scale by the divisor
			side_s2 <= side_s1;
			omx_s2  <= omx_s1;
			omy_s2  <= omy_s1;
			fbn_s2  <= 41'(FB_Q24) * 41'(n_s1);
			bn_s2   <= 32'(B_Q24) * 32'(n_s1);
			// stage 3: depth dividend with half-divisor rounding, lateral products
			side_s3 <= side_s2;
			dz_s3   <= QUO_W'((fbn_s2 + 41'({side_s2.mag, 11'd0})) >> 12);
			px_s3   <= 58'(omx_s2) * 58'(bn_s2);
			py_s3   <= 58'(omy_s2) * 58'(bn_s2);
			// stage 4: lateral dividends
			side_s4 <= side_s3;
			dz_s4   <= dz_s3;
			dx_s4   <= QUO_W'((px_s3 + 58'({side_s3.mag, 27'd0})) >> 28);
			dy_s4   <= QUO_W'((py_s3 + 58'({side_s3.mag, 27'd0})) >> 28);
		end
	end

	// divide by the disparity magnitude
	logic             dv;
	d2wp_side_t       dside;
	logic [QUO_W-1:0] dq_z, dq_x, dq_y;

	d2wp_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_side   (side_s4),
		.in_z      (dz_s4),
		.in_x      (dx_s4),
		.in_y      (dy_s4),
		.out_valid (dv),
		.out_side  (dside),
		.out_z     (dq_z),
		.out_x     (dq_x),
		.out_y     (dq_y)
	);

	// stage 5: depth gate, apply signs
	logic               v_s5, v_s6, v_s7, v_s8;
	logic signed [QUO_W:0] cam_s5 [3];
	d2wp_color_t        col_s5, col_s6, col_s7, col_s8;
	logic signed [47:0] prod_s6 [3][3];
	logic signed [49:0] acc_s7 [3];
	logic signed [31:0] w_s8 [3];
	logic               gate_ok;

	assign gate_ok = dside.keep && (dq_z >= DEPTH_MIN_Q8) && (dq_z <= DEPTH_MAX_Q8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv && gate_ok;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cam_s5[0] <= dside.x_neg ? -$signed({1'b0, dq_x}) : $signed({1'b0, dq_x});
			cam_s5[1] <= dside.y_neg ? -$signed({1'b0, dq_y}) : $signed({1'b0, dq_y});
			cam_s5[2] <= dside.z_neg ? -$signed({1'b0, dq_z}) : $signed({1'b0, dq_z});
			col_s5    <= dside.color;
			col_s6    <= col_s5;
			col_s7    <= col_s6;
			col_s8    <= col_s7;
		end
	end

	// stage 6: rotation products; stage 7: row sums with rounding bias
	for (genvar k = 0; k < 3; k++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			always_ff @(posedge clk) begin
				if (en) begin
					prod_s6[k][j] <= 48'($signed(rot_q[k][j*ROT_W +: ROT_W]) * cam_s5[j]);
				end
			end
		end

		logic signed [34:0] sh_c;
		logic signed [35:0] sum_c;

		always_comb begin
			sh_c  = 35'(acc_s7[k] >>> 15);
			sum_c = 36'(sh_c) + 36'(trans_q[k]);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s7[k] <= 50'(prod_s6[k][0]) + 50'(prod_s6[k][1]) + 50'(prod_s6[k][2])
					+ 50'sd16384;
				// stage 8: floor shift, translate, saturate
				if (sum_c > 36'sd2147483647)
					w_s8[k] <= 32'sh7FFFFFFF;
				else if (sum_c < -36'sd2147483648)
					w_s8[k] <= 32'sh80000000;
				else
					w_s8[k] <= sum_c[31:0];
			end
		end
	end

	// output channel
	assign point.valid       = v_s8;
	assign point.world_x     = w_s8[0];
	assign point.world_y     = w_s8[1];
	assign point.world_z     = w_s8[2];
	assign point.point_red   = col_s8.red;
	assign point.point_green = col_s8.green;
	assign point.point_blue  = col_s8.blue;

	// checks
	`D2WP_ASSERT_NEXT(a_depth_gate, en && dv && (dq_z < DEPTH_MIN_Q8 || dq_z > DEPTH_MAX_Q8), !v_s5, "out-of-range depth not dropped")
	`D2WP_ASSERT_NEXT(a_stall_freeze, !en, $stable({v_s1, v_s4, dv, v_s5, v_s8}), "pipeline moved during stall")
	`D2WP_ASSERT_NOW(a_zero_disp, v_s1 && side_s1.mag == '0, !side_s1.keep, "zero disparity kept")

endmodule

// ----- hdl/d2wp_divider.sv -----
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on d2wp_pkg.
`timescale 1ns / 1ps
module d2wp_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  d2wp_pkg::d2wp_side_t           in_side,
	input  logic [d2wp_pkg::QUO_W-1:0]     in_z,
	input  logic [d2wp_pkg::QUO_W-1:0]     in_x,
	input  logic [d2wp_pkg::QUO_W-1:0]     in_y,
	output logic                           out_valid,
	output d2wp_pkg::d2wp_side_t           out_side,
	output logic [d2wp_pkg::QUO_W-1:0]     out_z,
	output logic [d2wp_pkg::QUO_W-1:0]     out_x,
	output logic [d2wp_pkg::QUO_W-1:0]     out_y
);
	import d2wp_pkg::*;

	logic       v_s    [1:QUO_W];
	d2wp_side_t side_s [1:QUO_W];
	d2wp_lane_t lz_s   [1:QUO_W];
	d2wp_lane_t lx_s   [1:QUO_W];
	d2wp_lane_t ly_s   [1:QUO_W];

	for (genvar g = 1; g <= QUO_W; g++) begin : g_stage
		logic       pv;
		d2wp_side_t ps;
		d2wp_lane_t pz, px, py;

		if (g == 1) begin : g_first
			assign pv = in_valid;
			assign ps = in_side;
			assign pz = '{nq: in_z, rem: '0};
			assign px = '{nq: in_x, rem: '0};
			assign py = '{nq: in_y, rem: '0};
		end else begin : g_next
			assign pv = v_s[g-1];
			assign ps = side_s[g-1];
			assign pz = lz_s[g-1];
			assign px = lx_s[g-1];
			assign py = ly_s[g-1];
		end

		// valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		// one quotient bit per lane
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g] <= ps;
				lz_s[g]   <= d2wp_div_step(pz, ps.mag);
				lx_s[g]   <= d2wp_div_step(px, ps.mag);
				ly_s[g]   <= d2wp_div_step(py, ps.mag);
			end
		end
	end

	assign out_valid = v_s[QUO_W];
	assign out_side  = side_s[QUO_W];
	assign out_z     = lz_s[QUO_W].nq;
	assign out_x     = lx_s[QUO_W].nq;
	assign out_y     = ly_s[QUO_W].nq;

endmodule

// ----- bench/disparity_to_world_point_unit_checker.sv -----
// Checker for the disparity reprojection unit: predicts world points from accepted pixels.
// Depends on d2wp_pkg and d2wp_if; watches the pixel and point channels and the config port.
`timescale 1ns / 1ps
module disparity_to_world_point_unit_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [d2wp_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [d2wp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	d2wp_pixel_if.sink                      pixel_mon,
	d2wp_point_if.sink                      point_mon,
	output int                              fail_count,
	output int                              pending_points,
	output int                              checked_points
);
	import d2wp_pkg::*;

	typedef struct {
		logic signed [31:0] wx;
		logic signed [31:0] wy;
		logic signed [31:0] wz;
		logic [7:0]         r;
		logic [7:0]         g;
		logic [7:0]         b;
	} world_point_t;

	localparam longint MAX_ROWS = 1024;
	localparam longint MAX_COLS = 1024;

	// shadow copy of the pose and divisor
	logic [53:0]        rot_shadow [3];
	logic signed [31:0] trans_shadow [3];
	logic [8:0]         divisor_shadow;

	world_point_t expected_points [$];

	assign pending_points = expected_points.size();

	// rounded quotient of magnitudes, ties away from zero
	function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
		return (num + den / 2) / den;
	endfunction

	function automatic longint lateral_offset(longint off_q16, longint unsigned n,
		longint unsigned mag, bit raw_neg);
		bit              neg;
		longint unsigned omag;
		longint unsigned q;
		neg  = (off_q16 < 0) != raw_neg;
		omag = off_q16 < 0 ? -off_q16 : off_q16;
		q    = round_div(omag * 64'd6956069 * n, mag << 28);
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [31:0] pose_axis(logic [53:0] rot_row,
		logic signed [31:0] t, longint x, longint y, longint z);
		longint acc;
		longint v;
		acc = longint'($signed(rot_row[17:0])) * x + longint'($signed(rot_row[35:18])) * y
			+ longint'($signed(rot_row[53:36])) * z + 16384;
		// arithmetic shift is floor division
		v = (acc >>> 15) + longint'(t);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	// one pixel in, zero or one point out
	task automatic predict_point(logic signed [15:0] raw, logic [9:0] row, logic [9:0] col,
		logic [7:0] b, logic [7:0] g, logic [7:0] r);
		longint unsigned n;
		longint unsigned mag;
		longint unsigned zmag;
		longint          x;
		longint          y;
		longint          z;
		bit              neg;
		world_point_t    p;
		if (raw == 0 || row >= MAX_ROWS || col >= MAX_COLS) return;
		n = divisor_shadow;
		if (n == 0) n = 1;
		if (n > 256) n = 256;
		neg  = raw < 0;
		mag  = neg ? -longint'(raw) : longint'(raw);
		zmag = round_div(64'd2249949020 * n, mag << 12);
		if (zmag < 256 || zmag > 512000000) return;
		z = neg ? -longint'(zmag) : longint'(zmag);
		x = lateral_offset((longint'(col) << 16) - 20462114, n, mag, neg);
		y = lateral_offset((longint'(row) << 16) - 16518889, n, mag, neg);
		p.wx = pose_axis(rot_shadow[0], trans_shadow[0], x, y, z);
		p.wy = pose_axis(rot_shadow[1], trans_shadow[1], x, y, z);
		p.wz = pose_axis(rot_shadow[2], trans_shadow[2], x, y, z);
		p.r  = r;
		p.g  = g;
		p.b  = b;
		// append at the tail
		expected_points = {expected_points, p};
	endtask

	task automatic report_mismatch(string what);
		fail_count++;
		if (fail_count <= 10) $display("point mismatch: %s", what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		world_point_t e;
		if (!arst_n) begin
			rot_shadow[0]  = 54'd32768;
			rot_shadow[1]  = 54'd32768 << 18;
			rot_shadow[2]  = 54'd32768 << 36;
			trans_shadow   = '{0, 0, 0};
			divisor_shadow = 9'd64;
			expected_points.delete();
			fail_count     = 0;
			checked_points = 0;
		end else begin
			// compare the point transfer first, it cannot depend on this cycle's pixel
			if (point_mon.valid && point_mon.ready) begin
				checked_points++;
				if (expected_points.size() == 0) begin
					report_mismatch($sformatf("unexpected point x=%0d y=%0d z=%0d",
						point_mon.world_x, point_mon.world_y, point_mon.world_z));
				end else begin
					e = expected_points.pop_front();
					if (point_mon.world_x !== e.wx || point_mon.world_y !== e.wy ||
						point_mon.world_z !== e.wz || point_mon.point_red !== e.r ||
						point_mon.point_green !== e.g || point_mon.point_blue !== e.b)
						report_mismatch($sformatf(
							"exp %0d %0d %0d rgb %0d %0d %0d got %0d %0d %0d rgb %0d %0d %0d",
							e.wx, e.wy, e.wz, e.r, e.g, e.b, point_mon.world_x,
							point_mon.world_y, point_mon.world_z, point_mon.point_red,
							point_mon.point_green, point_mon.point_blue));
				end
			end
			if (pixel_mon.valid && pixel_mon.ready)
				predict_point(pixel_mon.raw_disparity, pixel_mon.pixel_row,
					pixel_mon.pixel_column, pixel_mon.blue, pixel_mon.green, pixel_mon.red);
			if (cfg_wr_en) begin
				case (d2wp_cfg_idx_t'(cfg_addr))
					CFG_ROT0: rot_shadow[0] = cfg_wdata;
					CFG_ROT1: rot_shadow[1] = cfg_wdata;
					CFG_ROT2: rot_shadow[2] = cfg_wdata;
					CFG_TX: trans_shadow[0] = cfg_wdata[31:0];
					CFG_TY: trans_shadow[1] = cfg_wdata[31:0];
					CFG_TZ: trans_shadow[2] = cfg_wdata[31:0];
					CFG_DIV: divisor_shadow = cfg_wdata[8:0];
					default: ;
				endcase
			end
		end
	end
endmodule

// ----- bench/disparity_to_world_point_unit_tb.sv -----
// Testbench top for the disparity reprojection unit: clock, reset, stimulus, verdict.
// Depends on d2wp_pkg, d2wp_if, the unit and disparity_to_world_point_unit_checker.
`timescale 1ns / 1ps
module disparity_to_world_point_unit_tb;
	import d2wp_pkg::*;

	localparam int PIPE_LATENCY = 37;
	localparam longint CYCLE_LIMIT = 400000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fail_count;
	int                    pending_points;
	int                    checked_points;
	int                    pixels_sent;
	longint                cycle_count;

	d2wp_pixel_if pixel ();
	d2wp_point_if point ();

	disparity_to_world_point_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.pixel     (pixel.sink),
		.point     (point.source)
	);

	disparity_to_world_point_unit_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.pixel_mon      (pixel.sink),
		.point_mon      (point.sink),
		.fail_count     (fail_count),
		.pending_points (pending_points),
		.checked_points (checked_points)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("disparity_to_world_point_unit_tb: FAIL");
			$finish;
		end
	end

	// no gap half the time, otherwise mostly a short gap and now and then a long one
	function automatic int gap_len();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50) return 0;
		if (sel < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver stalls at random, with stretches of always ready
	initial begin
		int stall;
		point.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0) begin
				point.ready = 1'b1;
				repeat ($urandom_range(50, 200)) @(negedge clk);
			end
			stall = gap_len();
			point.ready = (stall == 0);
			if (stall > 0) begin
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	task automatic write_reg(d2wp_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// wait for every predicted point, then let the pipe empty of rejected pixels
	task automatic drain_pipe();
		while (pending_points != 0) @(negedge clk);
		repeat (PIPE_LATENCY + 5) @(negedge clk);
	endtask

	function automatic void pixel_sent_inc();
		pixels_sent++;
	endfunction

	// one transfer on the pixel channel; called at a falling edge
	task automatic send_pixel(logic signed [15:0] raw, logic [9:0] row, logic [9:0] col,
		logic [7:0] b, logic [7:0] g, logic [7:0] r, bit allow_gap);
		int gap;
		gap = allow_gap ? gap_len() : 0;
		if (gap > 0) begin
			pixel.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel.valid         = 1'b1;
		pixel.raw_disparity = raw;
		pixel.pixel_row     = row;
		pixel.pixel_column  = col;
		pixel.blue          = b;
		pixel.green         = g;
		pixel.red           = r;
		@(posedge clk);
		while (!pixel.ready) @(posedge clk);
		pixel_sent_inc();
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] random_disparity();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7) return 16'($urandom_range(1, 4000));
		if (sel < 9) return -16'($urandom_range(1, 4000));
		return 16'($urandom);
	endfunction

	function automatic logic [17:0] random_coef();
		case ($urandom_range(0, 4))
			0: return 18'h08000;
			1: return 18'h38000;
			2: return 18'h1FFFF;
			3: return 18'h20000;
			default: return 18'($urandom);
		endcase
	endfunction

	task automatic random_pose();
		write_reg(CFG_ROT0, {random_coef(), random_coef(), random_coef()});
		write_reg(CFG_ROT1, {random_coef(), random_coef(), random_coef()});
		write_reg(CFG_ROT2, {random_coef(), random_coef(), random_coef()});
		write_reg(CFG_TX, 54'($urandom));
		write_reg(CFG_TY, 54'($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'($urandom)));
		write_reg(CFG_TZ, 54'($urandom_range(0, 1) ? 32'h80000000 : 32'($urandom)));
		write_reg(CFG_DIV, 54'($urandom_range(0, 511)));
	endtask

	task automatic random_batch(int count);
		repeat (count)
			send_pixel(random_disparity(), 10'($urandom), 10'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom), 1'b1);
		pixel.valid = 1'b0;
	endtask

	initial begin
		cycle_count         = 0;
		pixels_sent         = 0;
		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_addr            = '0;
		cfg_wdata           = '0;
		pixel.valid         = 1'b0;
		pixel.raw_disparity = '0;
		pixel.pixel_row     = '0;
		pixel.pixel_column  = '0;
		pixel.blue          = '0;
		pixel.green         = '0;
		pixel.red           = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, zero and negative disparity, reset pose
		send_pixel(16'sd0, 10'd100, 10'd100, 8'd1, 8'd2, 8'd3, 1'b0);
		send_pixel(16'sd1, 10'd0, 10'd0, 8'd255, 8'd0, 8'd255, 1'b0);
		send_pixel(16'sd32767, 10'd1023, 10'd1023, 8'd0, 8'd255, 8'd0, 1'b0);
		send_pixel(-16'sd32768, 10'd0, 10'd1023, 8'hAA, 8'h55, 8'hFF, 1'b0);
		send_pixel(-16'sd1, 10'd1023, 10'd0, 8'h55, 8'hAA, 8'h00, 1'b0);
		send_pixel(16'sd16, 10'd252, 10'd312, 8'd10, 8'd20, 8'd30, 1'b0);
		send_pixel(-16'sd200, 10'd512, 10'd640, 8'd7, 8'd8, 8'd9, 1'b0);
		send_pixel(16'sd2197, 10'd1, 10'd2, 8'd4, 8'd5, 8'd6, 1'b0);
		send_pixel(16'sd2198, 10'd3, 10'd4, 8'd4, 8'd5, 8'd6, 1'b0);
		pixel.valid = 1'b0;
		drain_pipe();

		// divisor at its extremes and beyond, near-full rotation, large translations
		write_reg(CFG_DIV, 54'd0);
		write_reg(CFG_ROT0, {18'h1FFFF, 18'h20000, 18'h1FFFF});
		write_reg(CFG_TX, 54'h0_7FFF_FFFF);
		write_reg(CFG_TY, 54'h0_8000_0000);
		write_reg(CFG_TZ, 54'h0_0000_0100);
		send_pixel(16'sd1, 10'd0, 10'd0, 8'd1, 8'd1, 8'd1, 1'b0);
		send_pixel(16'sd8, 10'd1023, 10'd1023, 8'd2, 8'd2, 8'd2, 1'b0);
		send_pixel(-16'sd3, 10'd500, 10'd0, 8'd3, 8'd3, 8'd3, 1'b0);
		pixel.valid = 1'b0;
		drain_pipe();
		write_reg(CFG_DIV, 54'd511);
		write_reg(CFG_ROT1, {18'h20000, 18'h20000, 18'h20000});
		write_reg(CFG_ROT2, 54'h3F_FFFF_FFFF_FFFF);
		send_pixel(16'sd1, 10'd0, 10'd1023, 8'd9, 8'd9, 8'd9, 1'b0);
		send_pixel(16'sd32767, 10'd1023, 10'd0, 8'd8, 8'd8, 8'd8, 1'b0);
		send_pixel(-16'sd1, 10'd0, 10'd0, 8'd7, 8'd7, 8'd7, 1'b0);
		pixel.valid = 1'b0;
		drain_pipe();
		write_reg(CFG_DIV, 54'd256);
		send_pixel(16'sd4, 10'd700, 10'd300, 8'd6, 8'd6, 8'd6, 1'b0);
		pixel.valid = 1'b0;
		drain_pipe();
		write_reg(CFG_DIV, 54'd1);

		// random phases, each under a fresh pose; a full drain between phases
		repeat (8) begin
			random_pose();
			random_batch(50);
			drain_pipe();
		end

		$display("sent %0d pixels, checked %0d world points", pixels_sent, checked_points);
		$display("covered the reset pose, three directed settings and eight random poses");
		if (fail_count == 0)
			$display("disparity_to_world_point_unit_tb: PASS");
		else
			$display("disparity_to_world_point_unit_tb: FAIL");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/d2wp_pkg.sv
hdl/d2wp_if.sv
hdl/d2wp_divider.sv
hdl/disparity_to_world_point_unit.sv
bench/disparity_to_world_point_unit_checker.sv
bench/disparity_to_world_point_unit_tb.sv
